@@ sv/vpfc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes, coefficients and arithmetic helpers for the pixel format converter.
// No dependencies; every other file of the block uses this package.
package vpfc_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int OP_W   = 2;
    localparam int COEF_W = 16;
    localparam int SUM_W  = 25;   // holds any signed Q15 sum of three weighted bytes
    localparam int QUO_W  = 11;   // holds a quotient plus the chroma offset, signed

    localparam int Q15_SHIFT   = 15;
    localparam int Q15_ROUND   = 32767;
    localparam int CHROMA_BIAS = 128;
    localparam int BYTE_MAX    = 255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int CNT_W       = QUEUE_AW + 1;

    // Source modes as written to the mode register.
    localparam logic [MODE_W-1:0] MODE_YUV422 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_YUV411 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB    = 2'd2;

    // Work classes decided at the front.
    localparam logic [OP_W-1:0] OP_PASS  = 2'd0;
    localparam logic [OP_W-1:0] OP_SPLIT = 2'd1;
    localparam logic [OP_W-1:0] OP_RGB   = 2'd2;

    // Coefficients, row by row for Y, U, V; columns are R, G, B.
    localparam int NUM_COEF = 9;
    localparam logic signed [COEF_W-1:0] COEF [0:NUM_COEF-1] = '{
        16'sd9798,   16'sd19235,  16'sd3736,
        -16'sd4784,  -16'sd9437,  16'sd14221,
        16'sd20218,  -16'sd16941, -16'sd3277
    };

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        byte_t           a;
        byte_t           b;
        byte_t           c;
        byte_t           d;
        byte_t           e;
        byte_t           f;
        logic            fe;
    } item_t;

    typedef struct packed {
        byte_t y0;
        byte_t u;
        byte_t y1;
        byte_t v;
        logic  last;
        logic  fe;
    } grp_t;

    function automatic logic signed [SUM_W-1:0] coef_mul(
        input byte_t x,
        input logic signed [COEF_W-1:0] k
    );
        logic signed [SUM_W-1:0] xs;
        logic signed [SUM_W-1:0] ks;
        xs = $signed({{(SUM_W-BYTE_W){1'b0}}, x});
        ks = SUM_W'(k);
        coef_mul = xs * ks;
    endfunction

    // Truncating division by 2^15, optional chroma offset, clamp to a byte.
    function automatic byte_t q15_to_byte(
        input logic signed [SUM_W-1:0] s,
        input logic bias
    );
        logic signed [SUM_W-1:0] adj;
        logic signed [QUO_W-1:0] q;
        adj = s[SUM_W-1] ? (s + SUM_W'(Q15_ROUND)) : s;
        q   = QUO_W'(adj >>> Q15_SHIFT);
        if (bias)
        begin
            q = q + QUO_W'(CHROMA_BIAS);
        end
        if (q < 0)
        begin
            q15_to_byte = '0;
        end
        else if (q > QUO_W'(BYTE_MAX))
        begin
            q15_to_byte = byte_t'(BYTE_MAX);
        end
        else
        begin
            q15_to_byte = q[BYTE_W-1:0];
        end
    endfunction

endpackage

@@ sv/vpfc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: source pixel bytes in, YUYV groups out.
// Depends on vpfc_pkg for the byte width.
interface vpfc_pix_if;
    logic                          valid;
    logic                          ready;
    logic [vpfc_pkg::BYTE_W-1:0]   in_byte_a;
    logic [vpfc_pkg::BYTE_W-1:0]   in_byte_b;
    logic [vpfc_pkg::BYTE_W-1:0]   in_byte_c;
    logic [vpfc_pkg::BYTE_W-1:0]   in_byte_d;
    logic [vpfc_pkg::BYTE_W-1:0]   in_byte_e;
    logic [vpfc_pkg::BYTE_W-1:0]   in_byte_f;
    logic                          frame_end;

    modport source (
        output valid, in_byte_a, in_byte_b, in_byte_c, in_byte_d, in_byte_e, in_byte_f,
               frame_end,
        input  ready
    );
    modport sink (
        input  valid, in_byte_a, in_byte_b, in_byte_c, in_byte_d, in_byte_e, in_byte_f,
               frame_end,
        output ready
    );
endinterface

interface vpfc_grp_if;
    logic                          valid;
    logic                          ready;
    logic [vpfc_pkg::BYTE_W-1:0]   out_luma_first;
    logic [vpfc_pkg::BYTE_W-1:0]   out_chroma_blue;
    logic [vpfc_pkg::BYTE_W-1:0]   out_luma_second;
    logic [vpfc_pkg::BYTE_W-1:0]   out_chroma_red;
    logic                          last_of_run;
    logic                          frame_end_out;

    modport source (
        output valid, out_luma_first, out_chroma_blue, out_luma_second, out_chroma_red,
               last_of_run, frame_end_out,
        input  ready
    );
    modport sink (
        input  valid, out_luma_first, out_chroma_blue, out_luma_second, out_chroma_red,
               last_of_run, frame_end_out,
        output ready
    );
endinterface

@@ sv/vpfc_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified items between the front and back parts.
// Depends on vpfc_pkg for the item type and depth.
module vpfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vpfc_pkg::item_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output vpfc_pkg::item_t pop_data
);

    vpfc_pkg::item_t                  mem_reg [0:vpfc_pkg::QUEUE_DEPTH-1];
    logic [vpfc_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [vpfc_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [vpfc_pkg::CNT_W-1:0]       count_reg;
    logic [vpfc_pkg::CNT_W-1:0]       count_next;

    assign full     = (count_reg == vpfc_pkg::CNT_W'(vpfc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/vpfc_front.sv @@
`timescale 1ns / 1ps
// Front part: holds the mode register, accepts pixel transfers and classifies them.
// Depends on vpfc_pkg and the vpfc_pix_if interface.
module vpfc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    vpfc_pix_if.sink                     pixels,
    input  logic                         cfg_we,
    input  logic [vpfc_pkg::MODE_W-1:0]  cfg_data,
    output logic                         push,
    output vpfc_pkg::item_t              push_data,
    input  logic                         full
);

    logic [vpfc_pkg::MODE_W-1:0] mode_reg;
    logic                        valid_reg;
    vpfc_pkg::item_t             item_reg;
    vpfc_pkg::item_t             item_next;
    logic                        take;

    assign push         = valid_reg && !full;
    assign push_data    = item_reg;
    assign pixels.ready = !valid_reg || !full;
    assign take         = pixels.valid && pixels.ready;

    always_comb
    begin
        item_next.a  = pixels.in_byte_a;
        item_next.b  = pixels.in_byte_b;
        item_next.c  = pixels.in_byte_c;
        item_next.d  = pixels.in_byte_d;
        item_next.e  = pixels.in_byte_e;
        item_next.f  = pixels.in_byte_f;
        item_next.fe = pixels.frame_end;
        case (mode_reg)
            vpfc_pkg::MODE_YUV411: item_next.op = vpfc_pkg::OP_SPLIT;
            vpfc_pkg::MODE_RGB:    item_next.op = vpfc_pkg::OP_RGB;
            default:               item_next.op = vpfc_pkg::OP_PASS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= vpfc_pkg::MODE_YUV422;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (pixels.ready)
            begin
                valid_reg <= pixels.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ sv/vpfc_back.sv @@
`timescale 1ns / 1ps
// Back part: issues YUYV groups from the queue head and runs the four-stage Q15 pipeline.
// Depends on vpfc_pkg and the vpfc_grp_if interface.
module vpfc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  vpfc_pkg::item_t head,
    output logic            pop,
    vpfc_grp_if.source      groups
);

    localparam int NUM_PROD = 2 * vpfc_pkg::NUM_COEF;
    localparam int NUM_SUM  = 6;

    logic phase_reg;
    logic issue;
    logic split_first;
    vpfc_pkg::grp_t issue_grp;
    vpfc_pkg::byte_t px [0:5];

    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_rgb_reg, s2_rgb_reg, s3_rgb_reg;
    vpfc_pkg::grp_t s1_grp_reg, s2_grp_reg, s3_grp_reg, s4_grp_reg;
    logic signed [vpfc_pkg::SUM_W-1:0] s1_prod_reg [0:NUM_PROD-1];
    logic signed [vpfc_pkg::SUM_W-1:0] prod_next   [0:NUM_PROD-1];
    logic signed [vpfc_pkg::SUM_W-1:0] s2_sum_reg  [0:NUM_SUM-1];
    logic signed [vpfc_pkg::SUM_W-1:0] sum_next    [0:NUM_SUM-1];
    vpfc_pkg::byte_t                   s3_yuv_reg  [0:NUM_SUM-1];
    vpfc_pkg::byte_t                   yuv_next    [0:NUM_SUM-1];
    vpfc_pkg::grp_t                    out_next;
    logic [vpfc_pkg::BYTE_W:0]         u_pair;
    logic [vpfc_pkg::BYTE_W:0]         v_pair;

    // Ready chain runs back from the output register.
    assign s4_ready = !s4_valid_reg || groups.ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign split_first = (head.op == vpfc_pkg::OP_SPLIT) && !phase_reg;
    assign issue       = !empty && s1_ready;
    assign pop         = issue && !split_first;

    always_comb
    begin
        px[0] = head.a;
        px[1] = head.b;
        px[2] = head.c;
        px[3] = head.d;
        px[4] = head.e;
        px[5] = head.f;
    end

    // A 4:1:1 item leaves as two groups that share its chroma bytes.
    always_comb
    begin
        issue_grp.last = 1'b1;
        issue_grp.fe   = head.fe;
        case (head.op)
            vpfc_pkg::OP_SPLIT:
            begin
                issue_grp.u = head.a;
                issue_grp.v = head.d;
                if (!phase_reg)
                begin
                    issue_grp.y0   = head.b;
                    issue_grp.y1   = head.c;
                    issue_grp.last = 1'b0;
                    issue_grp.fe   = 1'b0;
                end
                else
                begin
                    issue_grp.y0 = head.e;
                    issue_grp.y1 = head.f;
                end
            end
            default:
            begin
                issue_grp.y0 = head.a;
                issue_grp.u  = head.b;
                issue_grp.y1 = head.c;
                issue_grp.v  = head.d;
            end
        endcase
    end

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_next[p * 9 + k * 3 + c] =
                        vpfc_pkg::coef_mul(px[p * 3 + c], vpfc_pkg::COEF[k * 3 + c]);
                end
            end
        end
    end

    // Sum order: Y0, U0, V0, Y1, U1, V1.
    always_comb
    begin
        for (int i = 0; i < NUM_SUM; i++)
        begin
            sum_next[i] = s1_prod_reg[i * 3] + s1_prod_reg[i * 3 + 1]
                        + s1_prod_reg[i * 3 + 2];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SUM; i++)
        begin
            yuv_next[i] = vpfc_pkg::q15_to_byte(s2_sum_reg[i], (i % 3) != 0);
        end
    end

    always_comb
    begin
        u_pair   = {1'b0, s3_yuv_reg[1]} + {1'b0, s3_yuv_reg[4]};
        v_pair   = {1'b0, s3_yuv_reg[2]} + {1'b0, s3_yuv_reg[5]};
        out_next = s3_grp_reg;
        if (s3_rgb_reg)
        begin
            out_next.y0 = s3_yuv_reg[0];
            out_next.u  = u_pair[vpfc_pkg::BYTE_W:1];
            out_next.y1 = s3_yuv_reg[3];
            out_next.v  = v_pair[vpfc_pkg::BYTE_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue && (head.op == vpfc_pkg::OP_SPLIT))
            begin
                phase_reg <= !phase_reg;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_grp_reg  <= issue_grp;
            s1_rgb_reg  <= (head.op == vpfc_pkg::OP_RGB);
            s1_prod_reg <= prod_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_grp_reg <= s1_grp_reg;
            s2_rgb_reg <= s1_rgb_reg;
            s2_sum_reg <= sum_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_grp_reg <= s2_grp_reg;
            s3_rgb_reg <= s2_rgb_reg;
            s3_yuv_reg <= yuv_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_grp_reg <= out_next;
        end
    end

    assign groups.valid           = s4_valid_reg;
    assign groups.out_luma_first  = s4_grp_reg.y0;
    assign groups.out_chroma_blue = s4_grp_reg.u;
    assign groups.out_luma_second = s4_grp_reg.y1;
    assign groups.out_chroma_red  = s4_grp_reg.v;
    assign groups.last_of_run     = s4_grp_reg.last;
    assign groups.frame_end_out   = s4_grp_reg.fe;

endmodule

@@ sv/video_pixel_format_converter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the camera pixel format converter producing packed YUYV 4:2:2 groups.
// Depends on vpfc_pkg, vpfc_if, vpfc_front, vpfc_queue and vpfc_back.
//
// Usage:
// The pixels channel takes one transfer of six source bytes plus a frame-end mark.
// The groups channel delivers YUYV groups (Y0, U, Y1, V), with last_of_run set on the
// final group caused by a source transfer and frame_end_out copying the frame-end mark there.
// The two-bit source mode is written through cfg_we/cfg_data while the block is idle:
// 0 passes the first four bytes through, 1 splits a 4:1:1 transfer into two groups,
// 2 converts two RGB pixels with Q15 coefficients; code 3 acts as pass-through.
// A pixel transfer passes the front register, the queue and the four back stages.
// While the receiver takes groups, the block accepts one source transfer per cycle in
// modes 0, 2 and 3; in mode 1 the back part issues one group per cycle from the queue head.
// Reset clears the mode to pass-through and empties every stage; nothing is in flight.
// When the receiver stalls, the output register holds its group, the four back stages,
// the two-entry queue and the front register fill up, and only then does pixels.ready drop.
module video_pixel_format_converter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    vpfc_pix_if.sink                     pixels,
    vpfc_grp_if.source                   groups,
    input  logic                         cfg_we,
    input  logic [vpfc_pkg::MODE_W-1:0]  cfg_data
);

    // Front-to-queue and queue-to-back hand-off.
    logic            push;
    logic            full;
    logic            pop;
    logic            empty;
    vpfc_pkg::item_t push_data;
    vpfc_pkg::item_t head;

    // The front registers each accepted transfer with its work class, taken from the
    // mode register at acceptance time.
    vpfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // The queue decouples acceptance from the group sequencer, so a 4:1:1 item being
    // split does not stall the input side right away.
    vpfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (head)
    );

    // The back part issues groups and runs products, sums, divide-and-clamp and the
    // chroma averaging in separate stages, ending in the output register.
    vpfc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .groups (groups)
    );

endmodule

@@ sv/vpfc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the pixel format converter, bound to the top level.
// Depends only on the top-level port signals and vpfc_pkg for widths.
module vpfc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [vpfc_pkg::BYTE_W-1:0] out_luma_first,
    input logic [vpfc_pkg::BYTE_W-1:0] out_chroma_blue,
    input logic [vpfc_pkg::BYTE_W-1:0] out_luma_second,
    input logic [vpfc_pkg::BYTE_W-1:0] out_chroma_red,
    input logic                        last_of_run,
    input logic                        frame_end_out
);

    // Source transfers whose final group has not yet been taken.
    logic [3:0] open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 4'(in_valid && in_ready)
                      - 4'(out_valid && out_ready && last_of_run);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_luma_first)
            && $stable(out_chroma_blue) && $stable(out_luma_second)
            && $stable(out_chroma_red) && $stable(last_of_run) && $stable(frame_end_out))
        else $error("output group changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_fe_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !frame_end_out)
        else $error("frame end shown on a group that is not the last of its transfer");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> open_reg != 4'd0)
        else $error("final group with no source transfer outstanding");

endmodule

bind video_pixel_format_converter_unit vpfc_checker u_vpfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (pixels.valid),
    .in_ready        (pixels.ready),
    .out_valid       (groups.valid),
    .out_ready       (groups.ready),
    .out_luma_first  (groups.out_luma_first),
    .out_chroma_blue (groups.out_chroma_blue),
    .out_luma_second (groups.out_luma_second),
    .out_chroma_red  (groups.out_chroma_red),
    .last_of_run     (groups.last_of_run),
    .frame_end_out   (groups.frame_end_out)
);

@@ test/tb_video_pixel_format_converter_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the camera pixel format converter (YUYV 4:2:2 output).
// Depends on vpfc_pkg, the vpfc_if channel interfaces and video_pixel_format_converter_unit.
module tb_video_pixel_format_converter_unit;
    import vpfc_pkg::*;

    // Code 3 of the mode register has no name in the package; it behaves as pass-through.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Q15 weights of the color conversion, rows Y, U, V and columns R, G, B.
    localparam int KY_R = 9798;
    localparam int KY_G = 19235;
    localparam int KY_B = 3736;
    localparam int KU_R = -4784;
    localparam int KU_G = -9437;
    localparam int KU_B = 14221;
    localparam int KV_R = 20218;
    localparam int KV_G = -16941;
    localparam int KV_B = -3277;
    localparam int Q15_ONE = 32768;
    localparam int UV_OFFSET = 128;

    localparam int IDLE_PERCENT = 28;
    localparam int SETTLE_CYCLES = 12;     // lets the pipeline settle after the last group
    localparam int STALL_CYCLES = 150;     // long receiver hold-off, far above the block's depth
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        byte_t a;
        byte_t b;
        byte_t c;
        byte_t d;
        byte_t e;
        byte_t f;
        logic  fe;
    } pixel_item_t;

    bit   clk;
    logic rst_n;
    logic cfg_we;
    logic [MODE_W-1:0] cfg_data;

    vpfc_pix_if pixels_if ();
    vpfc_grp_if groups_if ();

    video_pixel_format_converter_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels_if),
        .groups   (groups_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Mode as the predictor sees it; it changes only while the block is idle.
    logic [MODE_W-1:0] active_mode = MODE_YUV422;

    // YUYV groups predicted for accepted pixel transfers, oldest first.
    grp_t pending_groups [$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Random idling on both channels is switched off for some phases to get
    // long back-to-back stretches.
    bit idle_on = 1'b1;

    // A long receiver hold-off is requested by bumping stall_req; the receiver
    // process sees the change and counts the hold-off down on its own.
    int stall_req = 0;
    int stall_ack;
    int stall_left;

    // The clock runs with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ends the run if the stimulus or the results stop making progress.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side of the group channel: random stalls, plus the long hold-off
    // that lets the block fill up and push back on its pixel input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_if.ready <= 1'b0;
            stall_ack <= 0;
            stall_left <= 0;
        end
        else if (stall_ack != stall_req)
        begin
            stall_ack <= stall_req;
            stall_left <= STALL_CYCLES - 1;
            groups_if.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            groups_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            groups_if.ready <= 1'b0;
        end
        else
        begin
            groups_if.ready <= 1'b1;
        end
    end

    // Every group transfer is compared with the oldest prediction. The outputs are
    // read at the clock edge, before any update scheduled for that edge lands.
    always @(posedge clk)
    begin
        grp_t seen;
        grp_t want;
        if (rst_n && groups_if.valid && groups_if.ready)
        begin
            seen.y0   = groups_if.out_luma_first;
            seen.u    = groups_if.out_chroma_blue;
            seen.y1   = groups_if.out_luma_second;
            seen.v    = groups_if.out_chroma_red;
            seen.last = groups_if.last_of_run;
            seen.fe   = groups_if.frame_end_out;
            if (pending_groups.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: group with nothing expected: Y0=%h U=%h Y1=%h V=%h last=%b fe=%b",
                             $realtime, seen.y0, seen.u, seen.y1, seen.v, seen.last, seen.fe);
                end
            end
            else
            begin
                want = pending_groups.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: group mismatch: expected Y0=%h U=%h Y1=%h V=%h last=%b fe=%b",
                                 $realtime, want.y0, want.u, want.y1, want.v, want.last, want.fe);
                        $display("%0t:                 actual Y0=%h U=%h Y1=%h V=%h last=%b fe=%b",
                                 $realtime, seen.y0, seen.u, seen.y1, seen.v, seen.last, seen.fe);
                    end
                end
            end
        end
    end

    // Divides a Q15 sum with truncation toward zero (as SystemVerilog integer
    // division does), adds the chroma offset and clamps to one byte.
    function automatic byte_t q15_to_sample(input int weighted, input int offset);
        int level;
        level = weighted / Q15_ONE + offset;
        if (level < 0)
        begin
            return 8'h00;
        end
        if (level > 255)
        begin
            return 8'hFF;
        end
        return byte_t'(level);
    endfunction

    function automatic void rgb_to_yuv_sample(input int r, input int g, input int b,
                                              output int y, output int u, output int v);
        y = q15_to_sample(KY_R * r + KY_G * g + KY_B * b, 0);
        u = q15_to_sample(KU_R * r + KU_G * g + KU_B * b, UV_OFFSET);
        v = q15_to_sample(KV_R * r + KV_G * g + KV_B * b, UV_OFFSET);
    endfunction

    // Predicts the YUYV groups of one accepted pixel transfer under the active mode.
    function automatic void convert_pixels(input pixel_item_t it);
        grp_t g;
        int y0, u0, v0, y1, u1, v1;
        case (active_mode)
            MODE_YUV411:
            begin
                // U,Y0,Y1,V,Y2,Y3 becomes two groups that share U and V.
                g.y0 = it.b;
                g.u = it.a;
                g.y1 = it.c;
                g.v = it.d;
                g.last = 1'b0;
                g.fe = 1'b0;
                pending_groups.push_back(g);
                g.y0 = it.e;
                g.y1 = it.f;
                g.last = 1'b1;
                g.fe = it.fe;
                pending_groups.push_back(g);
            end
            MODE_RGB:
            begin
                rgb_to_yuv_sample(int'(it.a), int'(it.b), int'(it.c), y0, u0, v0);
                rgb_to_yuv_sample(int'(it.d), int'(it.e), int'(it.f), y1, u1, v1);
                g.y0 = byte_t'(y0);
                g.u = byte_t'((u0 + u1) / 2);
                g.y1 = byte_t'(y1);
                g.v = byte_t'((v0 + v1) / 2);
                g.last = 1'b1;
                g.fe = it.fe;
                pending_groups.push_back(g);
            end
            default:
            begin
                // Pass-through, also for the unused code; the last two bytes are dropped.
                g.y0 = it.a;
                g.u = it.b;
                g.y1 = it.c;
                g.v = it.d;
                g.last = 1'b1;
                g.fe = it.fe;
                pending_groups.push_back(g);
            end
        endcase
    endfunction

    function automatic pixel_item_t make_pixels(input byte_t a, input byte_t b, input byte_t c,
                                                input byte_t d, input byte_t e, input byte_t f,
                                                input logic fe);
        pixel_item_t it;
        it.a = a;
        it.b = b;
        it.c = c;
        it.d = d;
        it.e = e;
        it.f = f;
        it.fe = fe;
        return it;
    endfunction

    // Byte values lean toward the ends of the range, where clamping happens.
    function automatic byte_t rand_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return 8'hFF;
        end
        return byte_t'($urandom_range(255));
    endfunction

    function automatic pixel_item_t rand_pixels();
        return make_pixels(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                           rand_byte(), rand_byte(), ($urandom_range(7) == 0));
    endfunction

    // Offers one pixel transfer, after random idle cycles, and returns at the edge
    // where it is accepted. Valid stays high so the next call can follow directly.
    task automatic send_pixels(input pixel_item_t it);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            pixels_if.valid <= 1'b0;
            @(posedge clk);
        end
        pixels_if.valid <= 1'b1;
        pixels_if.in_byte_a <= it.a;
        pixels_if.in_byte_b <= it.b;
        pixels_if.in_byte_c <= it.c;
        pixels_if.in_byte_d <= it.d;
        pixels_if.in_byte_e <= it.e;
        pixels_if.in_byte_f <= it.f;
        pixels_if.frame_end <= it.fe;
        @(posedge clk);
        while (!pixels_if.ready)
        begin
            @(posedge clk);
        end
        convert_pixels(it);
    endtask

    // Stops offering pixels, waits until every predicted group has arrived, and
    // lets the pipeline settle so that the block is idle afterwards.
    task automatic drain_groups();
        pixels_if.valid <= 1'b0;
        while (pending_groups.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the mode register; only called while the block is idle.
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        cfg_we <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_mode = mode;
    endtask

    // Pass-through straight after reset, which also shows the reset value of the
    // mode register. The last two bytes carry noise that must not show up.
    task automatic test_reset_passthrough();
        send_pixels(make_pixels(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
        send_pixels(make_pixels(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1));
        send_pixels(make_pixels(8'h55, 8'hAA, 8'h0F, 8'hF0, rand_byte(), rand_byte(), 1'b0));
        send_pixels(make_pixels(8'h12, 8'h34, 8'h56, 8'h78, rand_byte(), rand_byte(), 1'b1));
        drain_groups();
    endtask

    // 4:1:1 input splits into two groups; only the second carries the frame end.
    task automatic test_yuv411_split();
        write_mode(MODE_YUV411);
        send_pixels(make_pixels(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        send_pixels(make_pixels(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixels(make_pixels(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 1'b1));
        drain_groups();
    endtask

    // Color conversion: black and white, pure primaries whose chroma clamps at
    // both ends, and sums that are negative but not a multiple of the Q15 unit.
    task automatic test_rgb_conversion();
        write_mode(MODE_RGB);
        send_pixels(make_pixels(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixels(make_pixels(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1));
        send_pixels(make_pixels(8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0));
        send_pixels(make_pixels(8'h01, 8'h02, 8'h03, 8'hFA, 8'h80, 8'h07, 1'b1));
        send_pixels(make_pixels(8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b0));
        send_pixels(make_pixels(8'h7F, 8'h80, 8'h81, 8'h10, 8'hF0, 8'h33, 1'b1));
        drain_groups();
    endtask

    // The unused mode code must behave exactly like pass-through.
    task automatic test_unused_mode();
        write_mode(MODE_UNUSED);
        send_pixels(make_pixels(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'hFF, 8'h00, 1'b1));
        send_pixels(make_pixels(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0));
        drain_groups();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // split transfers, so the output stages and the queue fill and the pixel input
    // stalls. Afterwards the sender pauses until every group is out.
    task automatic test_output_backpressure();
        write_mode(MODE_YUV411);
        idle_on <= 1'b0;
        stall_req <= stall_req + 1;
        repeat (40) send_pixels(rand_pixels());
        drain_groups();
        idle_on <= 1'b1;
    endtask

    // Random content in every mode, each extreme of the register among them;
    // some phases run without idling on either side.
    task automatic test_random_streams();
        logic [MODE_W-1:0] plan [0:10];
        int phase;
        plan = '{MODE_RGB, MODE_YUV411, MODE_YUV422, MODE_UNUSED, MODE_RGB, MODE_YUV411,
                 MODE_RGB, MODE_YUV422, MODE_RGB, MODE_YUV411, MODE_UNUSED};
        for (phase = 0; phase < 11; phase++)
        begin
            idle_on <= (phase % 4 != 2);
            write_mode(plan[phase]);
            repeat (100) send_pixels(rand_pixels());
            drain_groups();
        end
        idle_on <= 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= MODE_YUV422;
        pixels_if.valid <= 1'b0;
        pixels_if.in_byte_a <= '0;
        pixels_if.in_byte_b <= '0;
        pixels_if.in_byte_c <= '0;
        pixels_if.in_byte_d <= '0;
        pixels_if.in_byte_e <= '0;
        pixels_if.in_byte_f <= '0;
        pixels_if.frame_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_passthrough();
        test_yuv411_split();
        test_rgb_conversion();
        test_unused_mode();
        test_output_backpressure();
        test_random_streams();

        if (mismatch_count == 0 && pending_groups.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
